// ===== rtl/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// shared types and constants of the first-fit block allocator
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

   localparam int ADDR_W = 32;
   localparam int LEN_W  = 29;
   localparam int SIZE_W = LEN_W + 1;   // rounded request can reach 2^29
   localparam int USED_W = 7;

   localparam logic [ADDR_W-1:0] REGION_BASE_RST  = 32'h0010_0000;
   localparam logic [LEN_W-1:0]  REGION_BYTES_RST = 29'd16777216;

   typedef enum logic [1:0] {
      CMD_INIT    = 2'd0,
      CMD_ALLOC   = 2'd1,
      CMD_RELEASE = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_DONE     = 2'd0,
      ST_NOFIT    = 2'd1,
      ST_NOTALLOC = 2'd2,
      ST_IGNORED  = 2'd3
   } status_type;

   typedef enum logic {
      CSR_REGION_BASE  = 1'b0,
      CSR_REGION_BYTES = 1'b1
   } csr_index_type;

   typedef enum logic [3:0] {
      S_BOOT,
      S_IDLE,
      S_A_SCAN,
      S_A_SPLIT,
      S_R_SCAN,
      S_R_MSCAN,
      S_R_SHIFT,
      S_RESP
   } state_type;

   typedef struct packed {
      logic [ADDR_W-1:0] base;
      logic [LEN_W-1:0]  length;
      logic              free;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

// ===== rtl/ffba_ram.sv =====
// ----------------------------------------------------------------------------
// ffba_ram
// simple dual-port ram, one write port, one read port with registered data
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ram #(
   parameter int WIDTH = 62,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// first-fit allocator over a table of blocks kept in one entry ram
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  command, request_size, release_address
//   rsp      out        rsp_valid/rsp_ready  granted_address, status, free_total,
//                                            entries_used
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// one command at a time; the single read port of the entry ram sets the pace
// allocate: walk the entries up to the first fit, then one more state for a split
// release: find, merge search, shift
// initialize and ignored commands: straight to the response state
// after reset the boot state writes entry 0 before the first beat is taken
// a finished result waits in the rsp register; the next beat is taken meanwhile
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator
   import ffba_pkg::*;
#(
   parameter int TABLE_ENTRIES = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,

   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [1:0]        req_command,
   input  wire logic [LEN_W-1:0]  req_request_size,
   input  wire logic [ADDR_W-1:0] req_release_address,

   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [ADDR_W-1:0]      rsp_granted_address,
   output logic [1:0]             rsp_status,
   output logic [LEN_W-1:0]       rsp_free_total,
   output logic [USED_W-1:0]      rsp_entries_used,

   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic              csr_index,
   input  wire logic [31:0]       csr_wdata
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   // a split is allowed only below this count, so the count never reaches the depth
   localparam logic [IDX_W-1:0] SPLIT_LIMIT = IDX_W'(TABLE_ENTRIES - 1);

   // control state
   state_type          state_ff, state_in;
   logic [IDX_W-1:0]   count_ff, count_in;
   logic [LEN_W-1:0]   free_ff, free_in;
   logic [ADDR_W-1:0]  region_base_ff;
   logic [LEN_W-1:0]   region_bytes_ff;

   // table walk: next index to read, and the read in flight
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;

   // command operands and the entry that was hit
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic [ADDR_W-1:0]  rel_addr_ff, rel_addr_in;
   logic [IDX_W-1:0]   hit_idx_ff, hit_idx_in;
   logic [ADDR_W-1:0]  hit_base_ff, hit_base_in;
   logic [LEN_W-1:0]   hit_len_ff, hit_len_in;
   logic [ADDR_W-1:0]  end_ff, end_in;

   // pending result
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   status_type         res_status_ff, res_status_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_load;
   logic [ADDR_W-1:0]  rsp_addr_ff;
   logic [1:0]         rsp_status_ff;
   logic [LEN_W-1:0]   rsp_free_ff;
   logic [USED_W-1:0]  rsp_used_ff;
   logic [IDX_W+USED_W-1:0] used_ext;

   // entry ram
   logic               ram_wr_en;
   logic [IDX_W-1:0]   ram_wr_addr;
   entry_type          ram_wr_data;
   logic               ram_rd_en;
   logic [IDX_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type          rd_entry;

   logic               req_fire;
   logic               alloc_hit, rel_hit, mrg_hit;
   logic               split_ok;
   logic               more;

   ffba_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry  = ram_rd_data;
   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   // first free entry large enough
   assign alloc_hit = rd_vld_ff && rd_entry.free && ({1'b0, rd_entry.length} >= size_ff);
   // allocated entry at the release address
   assign rel_hit   = rd_vld_ff && !rd_entry.free && (rd_entry.base == rel_addr_ff);
   // another free entry that starts where the released one ends
   assign mrg_hit   = rd_vld_ff && rd_entry.free && (rd_entry.base == end_ff)
                      && (rd_idx_ff != hit_idx_ff);
   assign split_ok  = ({1'b0, rd_entry.length} > size_ff) && (count_ff < SPLIT_LIMIT);
   assign more      = (scan_idx_ff < count_ff);

   assign used_ext  = {{USED_W{1'b0}}, count_ff};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      free_in       = free_ff;
      scan_idx_in   = scan_idx_ff;
      rd_vld_in     = 1'b0;
      rd_idx_in     = rd_idx_ff;
      size_in       = size_ff;
      rel_addr_in   = rel_addr_ff;
      hit_idx_in    = hit_idx_ff;
      hit_base_in   = hit_base_ff;
      hit_len_in    = hit_len_ff;
      end_in        = end_ff;
      res_addr_in   = res_addr_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_load      = 1'b0;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = hit_idx_ff;
      ram_wr_data   = '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = scan_idx_ff;

      case (state_ff)
         S_BOOT: begin
            // entry 0 spans the default region
            ram_wr_en          = 1'b1;
            ram_wr_addr        = '0;
            ram_wr_data.base   = REGION_BASE_RST;
            ram_wr_data.length = REGION_BYTES_RST;
            ram_wr_data.free   = 1'b1;
            state_in           = S_IDLE;
         end

         S_IDLE: begin
            if (req_fire) begin
               size_in       = ({1'b0, req_request_size} + SIZE_W'(3)) & ~SIZE_W'(3);
               rel_addr_in   = req_release_address;
               res_addr_in   = '0;
               res_status_in = ST_IGNORED;
               scan_idx_in   = '0;
               state_in      = S_RESP;
               case (req_command)
                  CMD_INIT: begin
                     ram_wr_en          = 1'b1;
                     ram_wr_addr        = '0;
                     ram_wr_data.base   = region_base_ff;
                     ram_wr_data.length = region_bytes_ff;
                     ram_wr_data.free   = 1'b1;
                     count_in           = IDX_W'(1);
                     free_in            = region_bytes_ff;
                     res_status_in      = ST_DONE;
                  end
                  CMD_ALLOC: begin
                     if (req_request_size != '0) begin
                        state_in = S_A_SCAN;
                     end
                  end
                  CMD_RELEASE: begin
                     if (req_release_address != '0) begin
                        state_in = S_R_SCAN;
                     end
                  end
                  default: begin
                     res_status_in = ST_IGNORED;
                  end
               endcase
            end
         end

         S_A_SCAN: begin
            if (alloc_hit) begin
               ram_wr_en          = 1'b1;
               ram_wr_addr        = rd_idx_ff;
               ram_wr_data.base   = rd_entry.base;
               ram_wr_data.length = split_ok ? size_ff[LEN_W-1:0] : rd_entry.length;
               ram_wr_data.free   = 1'b0;
               free_in            = free_ff - (split_ok ? size_ff[LEN_W-1:0]
                                                        : rd_entry.length);
               hit_base_in        = rd_entry.base;
               hit_len_in         = rd_entry.length;
               res_addr_in        = rd_entry.base;
               res_status_in      = ST_DONE;
               state_in           = split_ok ? S_A_SPLIT : S_RESP;
            end else if (more) begin
               ram_rd_en   = 1'b1;
               rd_vld_in   = 1'b1;
               rd_idx_in   = scan_idx_ff;
               scan_idx_in = scan_idx_ff + 1'b1;
            end else begin
               res_status_in = ST_NOFIT;
               state_in      = S_RESP;
            end
         end

         S_A_SPLIT: begin
            // remainder goes to a new free entry at the end of the table
            ram_wr_en          = 1'b1;
            ram_wr_addr        = count_ff;
            ram_wr_data.base   = hit_base_ff + ADDR_W'(size_ff);
            ram_wr_data.length = hit_len_ff - size_ff[LEN_W-1:0];
            ram_wr_data.free   = 1'b1;
            count_in           = count_ff + 1'b1;
            state_in           = S_RESP;
         end

         S_R_SCAN: begin
            if (rel_hit) begin
               ram_wr_en          = 1'b1;
               ram_wr_addr        = rd_idx_ff;
               ram_wr_data.base   = rd_entry.base;
               ram_wr_data.length = rd_entry.length;
               ram_wr_data.free   = 1'b1;
               free_in            = free_ff + rd_entry.length;
               hit_idx_in         = rd_idx_ff;
               hit_base_in        = rd_entry.base;
               hit_len_in         = rd_entry.length;
               end_in             = rd_entry.base + ADDR_W'(rd_entry.length);
               res_status_in      = ST_DONE;
               scan_idx_in        = '0;
               state_in           = S_R_MSCAN;
            end else if (more) begin
               ram_rd_en   = 1'b1;
               rd_vld_in   = 1'b1;
               rd_idx_in   = scan_idx_ff;
               scan_idx_in = scan_idx_ff + 1'b1;
            end else begin
               res_status_in = ST_NOTALLOC;
               state_in      = S_RESP;
            end
         end

         S_R_MSCAN: begin
            if (mrg_hit) begin
               // grow the released entry, then close the gap above the absorbed one
               ram_wr_en          = 1'b1;
               ram_wr_addr        = hit_idx_ff;
               ram_wr_data.base   = hit_base_ff;
               ram_wr_data.length = hit_len_ff + rd_entry.length;
               ram_wr_data.free   = 1'b1;
               scan_idx_in        = rd_idx_ff + 1'b1;
               state_in           = S_R_SHIFT;
            end else if (more) begin
               ram_rd_en   = 1'b1;
               rd_vld_in   = 1'b1;
               rd_idx_in   = scan_idx_ff;
               scan_idx_in = scan_idx_ff + 1'b1;
            end else begin
               state_in = S_RESP;
            end
         end

         S_R_SHIFT: begin
            // read entry k+1, then write it to k once the read data returns
            if (rd_vld_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = rd_idx_ff - 1'b1;
               ram_wr_data = rd_entry;
            end
            if (more) begin
               ram_rd_en   = 1'b1;
               rd_vld_in   = 1'b1;
               rd_idx_in   = scan_idx_ff;
               scan_idx_in = scan_idx_ff + 1'b1;
            end else begin
               count_in = count_ff - 1'b1;
               state_in = S_RESP;
            end
         end

         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_BOOT;
         count_ff        <= IDX_W'(1);
         free_ff         <= REGION_BYTES_RST;
         rd_vld_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         region_base_ff  <= REGION_BASE_RST;
         region_bytes_ff <= REGION_BYTES_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         free_ff      <= free_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REGION_BASE:  region_base_ff  <= csr_wdata;
               CSR_REGION_BYTES: region_bytes_ff <= csr_wdata[LEN_W-1:0];
               default:          region_base_ff  <= region_base_ff;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      scan_idx_ff   <= scan_idx_in;
      rd_idx_ff     <= rd_idx_in;
      size_ff       <= size_in;
      rel_addr_ff   <= rel_addr_in;
      hit_idx_ff    <= hit_idx_in;
      hit_base_ff   <= hit_base_in;
      hit_len_ff    <= hit_len_in;
      end_ff        <= end_in;
      res_addr_ff   <= res_addr_in;
      res_status_ff <= res_status_in;
      if (rsp_load) begin
         rsp_addr_ff   <= res_addr_ff;
         rsp_status_ff <= res_status_ff;
         rsp_free_ff   <= free_ff;
         rsp_used_ff   <= used_ext[USED_W-1:0];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_free_total      = rsp_free_ff;
   assign rsp_entries_used    = rsp_used_ff;

   // the table never empties
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      count_ff != '0)
      else $error("entry count dropped to zero");

   // the entry ram is quiet while waiting for a command
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE && !req_fire |-> !ram_wr_en)
      else $error("entry ram written while idle");

   // a split adds exactly one entry
   a_split_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_A_SPLIT |=> count_ff == $past(count_ff) + 1'b1)
      else $error("split did not add one entry");

   // a merge removes exactly one entry
   a_merge_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_R_SHIFT && state_in == S_RESP
      |=> count_ff == $past(count_ff) - 1'b1)
      else $error("merge did not remove one entry");

   // a finished command always lands in the output register
   a_resp_load: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP && (!rsp_valid_ff || rsp_ready) |=> rsp_valid_ff)
      else $error("result not presented");

endmodule

`default_nettype wire

// ===== tb/sv/first_fit_block_allocator_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_block_allocator_test
// self-checking bench for the first-fit block allocator: commands go in on
// the req channel, each is predicted by a shadow block table kept here, and
// each rsp beat is checked field by field against the oldest prediction
// ----------------------------------------------------------------------------

module first_fit_block_allocator_test;
   import ffba_pkg::*;

   localparam int TABLE_ENTRIES = 64;

   // command code with no meaning, block must ignore it
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   // what one rsp beat should carry
   typedef struct {
      logic [1:0]        command;
      logic [ADDR_W-1:0] address;
      status_type        status;
      logic [LEN_W-1:0]  free_total;
      logic [USED_W-1:0] used;
   } outcome_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;

   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_command = CMD_INIT;
   logic [LEN_W-1:0]    req_request_size = '0;
   logic [ADDR_W-1:0]   req_release_address = '0;

   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [ADDR_W-1:0]   rsp_granted_address;
   logic [1:0]          rsp_status;
   logic [LEN_W-1:0]    rsp_free_total;
   logic [USED_W-1:0]   rsp_entries_used;

   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_index = CSR_REGION_BASE;
   logic [31:0]         csr_wdata = '0;

   // shadow copy of the block table and the region registers
   logic [ADDR_W-1:0]   blk_base [TABLE_ENTRIES];
   logic [LEN_W-1:0]    blk_length [TABLE_ENTRIES];
   logic                blk_is_free [TABLE_ENTRIES];
   int                  blk_count;
   logic [LEN_W-1:0]    bytes_free;
   logic [ADDR_W-1:0]   region_base;
   logic [LEN_W-1:0]    region_bytes;

   outcome_type         awaited_outcomes [$];
   int unsigned         mismatch_count = 0;

   // idling knobs, percent of cycles
   int unsigned         send_idle_pct = 0;
   int unsigned         recv_stall_pct = 0;
   // long receiver hold-off, counted down by the ready process
   int unsigned         stall_hold = 0;

   first_fit_block_allocator #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_request_size(req_request_size),
      .req_release_address(req_release_address),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_granted_address(rsp_granted_address),
      .rsp_status(rsp_status),
      .rsp_free_total(rsp_free_total),
      .rsp_entries_used(rsp_entries_used),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // shadow table
   // ------------------------------------------------------------------------

   // one free block over the whole configured region
   function automatic void rebuild_table();
      blk_base[0]    = region_base;
      blk_length[0]  = region_bytes;
      blk_is_free[0] = 1'b1;
      blk_count      = 1;
      bytes_free     = region_bytes;
   endfunction

   // applies one command to the shadow table and returns its rsp beat
   function automatic outcome_type predict_outcome(input logic [1:0] cmd,
                                                   input logic [LEN_W-1:0] size,
                                                   input logic [ADDR_W-1:0] addr);
      outcome_type       o;
      logic [31:0]       need;
      logic [ADDR_W-1:0] stop;
      int                hit;
      int                i;
      int                k;
      o.command = cmd;
      o.address = '0;
      o.status  = ST_IGNORED;
      hit       = -1;
      case (cmd)
         CMD_INIT: begin
            rebuild_table();
            o.status = ST_DONE;
         end
         CMD_ALLOC: begin
            if (size != '0) begin
               // round up to four bytes, can reach 2^29 and then fits nothing
               need = ({3'b000, size} + 32'd3) & ~32'd3;
               for (i = 0; i < blk_count; i++) begin
                  if (blk_is_free[i] && {3'b000, blk_length[i]} >= need) begin
                     hit = i;
                     break;
                  end
               end
               if (hit < 0) begin
                  o.status = ST_NOFIT;
               end else begin
                  blk_is_free[hit] = 1'b0;
                  if ({3'b000, blk_length[hit]} > need && blk_count < TABLE_ENTRIES - 1) begin
                     // remainder goes to a new free entry at the end
                     blk_base[blk_count]    = blk_base[hit] + need;
                     blk_length[blk_count]  = blk_length[hit] - need[LEN_W-1:0];
                     blk_is_free[blk_count] = 1'b1;
                     blk_count++;
                     blk_length[hit] = need[LEN_W-1:0];
                     bytes_free      = bytes_free - need[LEN_W-1:0];
                  end else begin
                     // whole block granted, whole length leaves the free count
                     bytes_free = bytes_free - blk_length[hit];
                  end
                  o.address = blk_base[hit];
                  o.status  = ST_DONE;
               end
            end
         end
         CMD_RELEASE: begin
            if (addr != '0) begin
               for (i = 0; i < blk_count; i++) begin
                  if (blk_base[i] == addr && !blk_is_free[i]) begin
                     hit = i;
                     break;
                  end
               end
               if (hit < 0) begin
                  o.status = ST_NOTALLOC;
               end else begin
                  blk_is_free[hit] = 1'b1;
                  bytes_free = bytes_free + blk_length[hit];
                  stop = blk_base[hit] + {3'b000, blk_length[hit]};
                  // merge with one free block starting right after, table closes up
                  for (i = 0; i < blk_count; i++) begin
                     if (i != hit && blk_is_free[i] && blk_base[i] == stop) begin
                        blk_length[hit] = blk_length[hit] + blk_length[i];
                        for (k = i; k + 1 < blk_count; k++) begin
                           blk_base[k]    = blk_base[k + 1];
                           blk_length[k]  = blk_length[k + 1];
                           blk_is_free[k] = blk_is_free[k + 1];
                        end
                        blk_count--;
                        break;
                     end
                  end
                  o.status = ST_DONE;
               end
            end
         end
         default: begin
            o.status = ST_IGNORED;
         end
      endcase
      o.free_total = bytes_free;
      o.used       = blk_count[USED_W-1:0];
      return o;
   endfunction

   // base of some allocated block, 0 returned when none is held
   function automatic bit random_owned_address(output logic [ADDR_W-1:0] found);
      int unsigned held [$];
      int          i;
      found = '0;
      for (i = 0; i < blk_count; i++) begin
         if (!blk_is_free[i]) held.push_back(i);
      end
      if (held.size() == 0) return 1'b0;
      found = blk_base[held[$urandom_range(held.size() - 1)]];
      return 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // channel drivers
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      if (mismatch_count < 100) $display("%0t ns: %s", $time, what);
      mismatch_count++;
   endtask

   // offers one command beat, predicts it once it is taken; valid stays high
   task automatic issue_command(input logic [1:0] cmd, input logic [LEN_W-1:0] size,
                                input logic [ADDR_W-1:0] addr);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_command         <= cmd;
      req_request_size    <= size;
      req_release_address <= addr;
      do @(posedge clock); while (!req_ready);
      awaited_outcomes.push_back(predict_outcome(cmd, size, addr));
   endtask

   // sender goes quiet until every predicted beat has come back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_outcomes.size() != 0);
   endtask

   // both region registers, back to back; only while the block is idle
   task automatic program_region(input logic [31:0] base_word, input logic [31:0] bytes_word);
      csr_valid <= 1'b1;
      csr_index <= CSR_REGION_BASE;
      csr_wdata <= base_word;
      do @(posedge clock); while (!csr_ready);
      region_base = base_word;
      csr_index <= CSR_REGION_BYTES;
      csr_wdata <= bytes_word;
      do @(posedge clock); while (!csr_ready);
      region_bytes = bytes_word[LEN_W-1:0];
      csr_valid <= 1'b0;
   endtask

   // mostly legal traffic sized to the region, the rest is noise
   task automatic send_random_command();
      int unsigned       pick;
      int unsigned       scale;
      logic [ADDR_W-1:0] owned;
      logic [ADDR_W-1:0] any_addr;
      logic [LEN_W-1:0]  any_size;
      pick     = $urandom_range(99);
      any_addr = $urandom();
      any_size = LEN_W'($urandom());
      scale    = region_bytes >> $urandom_range(2, 7);
      if (scale == 0) scale = 1;
      if (pick >= 52 && pick < 84) begin
         if (!random_owned_address(owned)) pick = 0;
      end
      if (pick < 52)
         issue_command(CMD_ALLOC, LEN_W'($urandom_range(1, scale)), any_addr);
      else if (pick < 84)
         issue_command(CMD_RELEASE, any_size, owned);
      else if (pick < 89)
         issue_command(CMD_ALLOC, any_size, any_addr);
      else if (pick < 93)
         issue_command(CMD_RELEASE, any_size, any_addr);
      else if (pick < 95)
         issue_command(CMD_ALLOC, '0, any_addr);
      else if (pick < 96)
         issue_command(CMD_RELEASE, any_size, '0);
      else if (pick < 99)
         issue_command(CMD_UNKNOWN, any_size, any_addr);
      else
         issue_command(CMD_INIT, any_size, any_addr);
   endtask

   // rsp ready: long hold-off first, else random stalls
   always @(posedge clock) begin
      if (stall_hold != 0) begin
         rsp_ready <= 1'b0;
         stall_hold = stall_hold - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // every rsp beat against the oldest prediction
   always @(posedge clock) begin : score_results
      outcome_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_outcomes.size() == 0) begin
            report_mismatch("rsp beat with no command outstanding");
         end else begin
            want = awaited_outcomes.pop_front();
            if (rsp_granted_address !== want.address)
               report_mismatch($sformatf("cmd %0d granted_address %h, want %h",
                                         want.command, rsp_granted_address, want.address));
            if (rsp_status !== want.status)
               report_mismatch($sformatf("cmd %0d status %0d, want %0d",
                                         want.command, rsp_status, want.status));
            if (rsp_free_total !== want.free_total)
               report_mismatch($sformatf("cmd %0d free_total %0d, want %0d",
                                         want.command, rsp_free_total, want.free_total));
            if (rsp_entries_used !== want.used)
               report_mismatch($sformatf("cmd %0d entries_used %0d, want %0d",
                                         want.command, rsp_entries_used, want.used));
         end
      end
   end

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // reset region: ignored cases, rounding, no fit, release and merge
   task automatic test_directed_commands();
      issue_command(CMD_ALLOC, '0, 32'hFFFF_FFFF);           // zero size
      issue_command(CMD_RELEASE, 29'h1FFF_FFFF, '0);         // zero address
      issue_command(CMD_UNKNOWN, 29'h1FFF_FFFF, 32'hFFFF_FFFF);
      issue_command(CMD_RELEASE, '0, REGION_BASE_RST);       // block is free
      issue_command(CMD_ALLOC, 29'd1, '0);                   // rounds to 4
      issue_command(CMD_ALLOC, 29'd5, '0);                   // rounds to 8
      issue_command(CMD_ALLOC, 29'h1FFF_FFFF, '0);           // rounds to 2^29
      issue_command(CMD_ALLOC, 29'h1000_0000, '0);           // larger than region
      issue_command(CMD_RELEASE, '0, REGION_BASE_RST);
      issue_command(CMD_RELEASE, '0, REGION_BASE_RST);       // already free
      issue_command(CMD_RELEASE, '0, REGION_BASE_RST + 4);   // merges with remainder
      issue_command(CMD_ALLOC, 29'd4, '0);                   // exact fit, no split
      issue_command(CMD_ALLOC, 29'd16, '0);
      issue_command(CMD_RELEASE, '0, 32'hFFFF_FFFF);
      issue_command(CMD_INIT, 29'h1FFF_FFFF, 32'hFFFF_FFFF);
      issue_command(CMD_ALLOC, REGION_BYTES_RST, '0);        // whole region
      issue_command(CMD_ALLOC, 29'd4, '0);
      issue_command(CMD_RELEASE, '0, REGION_BASE_RST);
      issue_command(CMD_ALLOC, REGION_BYTES_RST - 3, '0);
      issue_command(CMD_INIT, '0, '0);
   endtask

   // region register extremes, address wrap, registers idle until initialize
   task automatic test_register_extremes();
      pause_until_drained();
      program_region(32'hFFFF_FFF0, 32'd32);
      issue_command(CMD_ALLOC, 29'd4, '0);                   // still the old region
      issue_command(CMD_INIT, '0, '0);
      issue_command(CMD_ALLOC, 29'd16, '0);
      issue_command(CMD_ALLOC, 29'd8, '0);                   // base wraps to 0
      issue_command(CMD_RELEASE, '0, '0);                    // address 0 ignored
      issue_command(CMD_ALLOC, 29'd8, '0);
      issue_command(CMD_RELEASE, '0, 32'hFFFF_FFF0);
      pause_until_drained();
      program_region(32'h0000_0000, 32'd4);
      issue_command(CMD_INIT, '0, '0);
      issue_command(CMD_ALLOC, 29'd1, '0);
      issue_command(CMD_ALLOC, 29'd1, '0);
      pause_until_drained();
      program_region(32'h8000_0000, 32'h1000_0000);
      issue_command(CMD_INIT, '0, '0);
      issue_command(CMD_ALLOC, 29'h1000_0000, '0);
      issue_command(CMD_RELEASE, '0, 32'h8000_0000);
      issue_command(CMD_ALLOC, 29'd3, '0);
      pause_until_drained();
      // upper data bits fall away, odd size leaves a 2 byte tail
      program_region(32'hFFFF_FFFF, {3'b111, 29'd1022});
      issue_command(CMD_INIT, '0, '0);
      issue_command(CMD_ALLOC, 29'd1022, '0);
      issue_command(CMD_ALLOC, 29'd1020, '0);
      issue_command(CMD_ALLOC, 29'd1, '0);
   endtask

   // fill the table until splits stop, then whole-block grants and merges
   task automatic test_full_table();
      logic [ADDR_W-1:0] held;
      pause_until_drained();
      program_region(32'h0004_0000, 32'd4096);
      issue_command(CMD_INIT, '0, '0);
      repeat (TABLE_ENTRIES - 2)
         issue_command(CMD_ALLOC, LEN_W'($urandom_range(1, 16)), $urandom());
      // table full: the remainder goes out whole
      issue_command(CMD_ALLOC, LEN_W'($urandom_range(1, 16)), $urandom());
      issue_command(CMD_ALLOC, 29'd4, $urandom());
      repeat (40) begin
         if (random_owned_address(held))
            issue_command(CMD_RELEASE, LEN_W'($urandom()), held);
      end
      repeat (20)
         issue_command(CMD_ALLOC, LEN_W'($urandom_range(1, 24)), $urandom());
   endtask

   // receiver holds off while the sender keeps offering beats
   task automatic test_stalled_results();
      pause_until_drained();
      program_region($urandom(), $urandom_range(256, 4096));
      issue_command(CMD_INIT, '0, '0);
      stall_hold = 400;
      repeat (30) send_random_command();
   endtask

   task automatic test_idle_phase(input int unsigned send_pct, input int unsigned stall_pct);
      pause_until_drained();
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
      if ($urandom_range(1) != 0)
         program_region($urandom(), $urandom_range(64, 16384));
      else
         program_region($urandom(), $urandom_range(4096, 268435456));
      issue_command(CMD_INIT, '0, '0);
      repeat (320) send_random_command();
   endtask

   initial begin
      region_base  = REGION_BASE_RST;
      region_bytes = REGION_BYTES_RST;
      rebuild_table();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_directed_commands();
      test_register_extremes();
      test_full_table();
      test_stalled_results();
      test_idle_phase(0, 0);
      test_idle_phase(48, 0);
      test_idle_phase(0, 48);
      test_idle_phase(26, 26);

      // last beats home, then room for a full-table release to stray out
      pause_until_drained();
      repeat (250) @(posedge clock);
      if (mismatch_count == 0 && awaited_outcomes.size() == 0) begin
         $display("first_fit_block_allocator_test passed");
      end else begin
         $display("first_fit_block_allocator_test failed");
      end
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("first_fit_block_allocator_test failed");
      $finish;
   end

endmodule
